// ===== src/barometer_raw_to_pressure_temperature_unit_defines.svh =====
// assertion macros for the barometer compensation unit
// included by the rtl files that carry concurrent checks
`ifndef BAROMETER_RAW_TO_PRESSURE_TEMPERATURE_UNIT_DEFINES_SVH
`define BAROMETER_RAW_TO_PRESSURE_TEMPERATURE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bpt_pkg.sv =====
// shared types, constants and helpers of the barometer compensation unit
// no dependencies
package bpt_pkg;

    localparam int DivStages = 32;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } bpt_cfg_idx_t;

    // side data that travels with a beat through the dividers
    typedef struct packed {
        logic [18:0] up;
        logic [31:0] x1;
        logic [15:0] temp;
        logic        flag;
        logic        err;
    } bpt_ctx_t;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_P_K1     = 32'd3038;
    localparam logic [31:0] C_P_K2     = 32'd7357;
    localparam logic [31:0] C_P_K3     = 32'd3791;
    localparam logic [31:0] C_HALF     = 32'd32768;
    localparam logic [31:0] C_TOP      = 32'h8000_0000;

    // arithmetic right shift of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

// ===== src/barometer_raw_to_pressure_temperature_unit.sv =====
// pipeline: two 32-stage dividers lie between input beat and result beat
// throughput: one beat per cycle; the whole pipeline stalls only while a result waits
// reset: aresetn synchronous active low, clears valid bits and calibration registers
// top level of the barometer compensation pipeline
// depends on bpt_pkg, bpt_udiv and the assertion macro header
`include "barometer_raw_to_pressure_temperature_unit_defines.svh"

module barometer_raw_to_pressure_temperature_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // temperature_tenths[15:0], pressure_pa[47:16]
    output logic        m_tuser,   // divide_error
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import bpt_pkg::*;

    // calibration registers
    logic [31:0] cal_ac1_ac2_reg, cal_ac3_ac4_reg, cal_ac5_ac6_reg, cal_b1_b2_reg, cal_mc_md_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_ac1_ac2_reg <= '0;
            cal_ac3_ac4_reg <= '0;
            cal_ac5_ac6_reg <= '0;
            cal_b1_b2_reg   <= '0;
            cal_mc_md_reg   <= '0;
            oss_reg         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_AC1_AC2: cal_ac1_ac2_reg <= cfg_wdata;
                REG_AC3_AC4: cal_ac3_ac4_reg <= cfg_wdata;
                REG_AC5_AC6: cal_ac5_ac6_reg <= cfg_wdata;
                REG_B1_B2:   cal_b1_b2_reg   <= cfg_wdata;
                REG_MC_MD:   cal_mc_md_reg   <= cfg_wdata;
                REG_OSS:     oss_reg         <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // coefficient decode
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = 32'($signed(cal_ac1_ac2_reg[31:16]));
    assign ac2 = 32'($signed(cal_ac1_ac2_reg[15:0]));
    assign ac3 = 32'($signed(cal_ac3_ac4_reg[31:16]));
    assign ac4 = {16'd0, cal_ac3_ac4_reg[15:0]};
    assign ac5 = {16'd0, cal_ac5_ac6_reg[31:16]};
    assign ac6 = {16'd0, cal_ac5_ac6_reg[15:0]};
    assign b1  = 32'($signed(cal_b1_b2_reg[31:16]));
    assign b2  = 32'($signed(cal_b1_b2_reg[15:0]));
    assign mc  = 32'($signed(cal_mc_md_reg[31:16]));
    assign md  = 32'($signed(cal_mc_md_reg[15:0]));

    // global advance: move when the output slot is free or being taken
    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // stage 1: temperature product
    logic        s1_vld_reg;
    logic [31:0] s1_prod_reg;
    logic [18:0] s1_up_reg;
    logic [31:0] s1_prod_next;
    assign s1_prod_next = ({16'd0, s_tdata[15:0]} - ac6) * ac5;

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_vld_reg <= 1'b0;
        else if (en) s1_vld_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prod_reg <= s1_prod_next;
            s1_up_reg   <= s_tdata[34:16];
        end
    end

    // stage 2: signed divide operands as magnitudes
    logic        s2_vld_reg;
    logic [31:0] s2_num_reg, s2_den_reg;
    bpt_ctx_t    s2_ctx_reg;
    logic [31:0] x1t, dent, numt;
    bpt_ctx_t    s2_ctx_next;
    assign x1t  = asr32(s1_prod_reg, 15);
    assign dent = x1t + md;
    assign numt = mc << 11;
    always_comb begin
        s2_ctx_next      = '0;
        s2_ctx_next.up   = s1_up_reg;
        s2_ctx_next.x1   = x1t;
        s2_ctx_next.flag = numt[31] ^ dent[31];
        s2_ctx_next.err  = (dent == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_vld_reg <= 1'b0;
        else if (en) s2_vld_reg <= s1_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s2_num_reg <= numt[31] ? (32'd0 - numt) : numt;
            s2_den_reg <= dent[31] ? (32'd0 - dent) : dent;
            s2_ctx_reg <= s2_ctx_next;
        end
    end

    // temperature divider
    logic        da_vld, da_busy;
    logic [31:0] da_quo;
    bpt_ctx_t    da_ctx;
    bpt_udiv u_div_temp (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(s2_vld_reg), .num(s2_num_reg), .den(s2_den_reg), .in_ctx(s2_ctx_reg),
        .out_vld(da_vld), .quo(da_quo), .out_ctx(da_ctx), .busy(da_busy)
    );

    // stage 3: b5, temperature, b6
    logic        s3_vld_reg;
    logic [31:0] s3_b6_reg;
    bpt_ctx_t    s3_ctx_reg;
    logic [31:0] x2t, b5;
    bpt_ctx_t    s3_ctx_next;
    assign x2t = da_ctx.flag ? (32'd0 - da_quo) : da_quo;
    assign b5  = da_ctx.x1 + x2t;
    always_comb begin
        s3_ctx_next      = da_ctx;
        s3_ctx_next.temp = 16'(asr32(b5 + 32'd8, 4));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_vld_reg <= 1'b0;
        else if (en) s3_vld_reg <= da_vld;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_b6_reg  <= b5 - C_B6_OFS;
            s3_ctx_reg <= s3_ctx_next;
        end
    end

    // stage 4: products of b6
    logic        s4_vld_reg;
    logic [31:0] s4_sq_reg, s4_ac2_reg, s4_ac3_reg;
    bpt_ctx_t    s4_ctx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s4_vld_reg <= 1'b0;
        else if (en) s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s4_sq_reg  <= s3_b6_reg * s3_b6_reg;
            s4_ac2_reg <= ac2 * s3_b6_reg;
            s4_ac3_reg <= ac3 * s3_b6_reg;
            s4_ctx_reg <= s3_ctx_reg;
        end
    end

    // stage 5: products of b6 squared
    logic        s5_vld_reg;
    logic [31:0] s5_b2_reg, s5_b1_reg, s5_x2a_reg, s5_x1c_reg;
    bpt_ctx_t    s5_ctx_reg;
    logic [31:0] b6sq;
    assign b6sq = asr32(s4_sq_reg, 12);
    always_ff @(posedge aclk) begin
        if (!aresetn) s5_vld_reg <= 1'b0;
        else if (en) s5_vld_reg <= s4_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s5_b2_reg  <= b2 * b6sq;
            s5_b1_reg  <= b1 * b6sq;
            s5_x2a_reg <= asr32(s4_ac2_reg, 11);
            s5_x1c_reg <= asr32(s4_ac3_reg, 13);
            s5_ctx_reg <= s4_ctx_reg;
        end
    end

    // stage 6: b3 and the b4 factor
    logic        s6_vld_reg;
    logic [31:0] s6_b3_reg, s6_x3_reg;
    bpt_ctx_t    s6_ctx_reg;
    logic [31:0] x3a;
    assign x3a = asr32(s5_b2_reg, 11) + s5_x2a_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s6_vld_reg <= 1'b0;
        else if (en) s6_vld_reg <= s5_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s6_b3_reg  <= asr32((((ac1 << 2) + x3a) << oss_reg) + 32'd2, 2);
            s6_x3_reg  <= asr32(s5_x1c_reg + asr32(s5_b1_reg, 16) + 32'd2, 2);
            s6_ctx_reg <= s5_ctx_reg;
        end
    end

    // stage 7: b4 product and pressure offset
    logic        s7_vld_reg;
    logic [31:0] s7_b4p_reg, s7_diff_reg;
    bpt_ctx_t    s7_ctx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s7_vld_reg <= 1'b0;
        else if (en) s7_vld_reg <= s6_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s7_b4p_reg  <= ac4 * (s6_x3_reg + C_HALF);
            s7_diff_reg <= {13'd0, s6_ctx_reg.up} - s6_b3_reg;
            s7_ctx_reg  <= s6_ctx_reg;
        end
    end

    // stage 8: b4 and b7
    logic        s8_vld_reg;
    logic [31:0] s8_b4_reg, s8_b7_reg;
    bpt_ctx_t    s8_ctx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s8_vld_reg <= 1'b0;
        else if (en) s8_vld_reg <= s7_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s8_b4_reg  <= s7_b4p_reg >> 15;
            s8_b7_reg  <= s7_diff_reg * (C_B7_SCALE >> oss_reg);
            s8_ctx_reg <= s7_ctx_reg;
        end
    end

    // pressure divide operands: branch on top bit of b7
    logic [31:0] db_num;
    bpt_ctx_t    db_in_ctx;
    assign db_num = s8_b7_reg[31] ? s8_b7_reg : (s8_b7_reg << 1);
    always_comb begin
        db_in_ctx      = s8_ctx_reg;
        db_in_ctx.flag = (s8_b7_reg >= C_TOP);
        db_in_ctx.err  = s8_ctx_reg.err || (s8_b4_reg == '0);
    end

    logic        db_vld, db_busy;
    logic [31:0] db_quo;
    bpt_ctx_t    db_ctx;
    bpt_udiv u_div_pres (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_vld(s8_vld_reg), .num(db_num), .den(s8_b4_reg), .in_ctx(db_in_ctx),
        .out_vld(db_vld), .quo(db_quo), .out_ctx(db_ctx), .busy(db_busy)
    );

    // stage 10: p
    logic        s10_vld_reg;
    logic [31:0] s10_p_reg;
    bpt_ctx_t    s10_ctx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s10_vld_reg <= 1'b0;
        else if (en) s10_vld_reg <= db_vld;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s10_p_reg   <= db_ctx.flag ? (db_quo << 1) : db_quo;
            s10_ctx_reg <= db_ctx;
        end
    end

    // stage 11: square of p/256 and linear term
    logic        s11_vld_reg;
    logic [31:0] s11_sq_reg, s11_k2_reg, s11_p_reg;
    bpt_ctx_t    s11_ctx_reg;
    logic [31:0] p8;
    assign p8 = asr32(s10_p_reg, 8);
    always_ff @(posedge aclk) begin
        if (!aresetn) s11_vld_reg <= 1'b0;
        else if (en) s11_vld_reg <= s10_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s11_sq_reg  <= p8 * p8;
            s11_k2_reg  <= C_P_K2 * s10_p_reg;
            s11_p_reg   <= s10_p_reg;
            s11_ctx_reg <= s10_ctx_reg;
        end
    end

    // stage 12: scaled square term
    logic        s12_vld_reg;
    logic [31:0] s12_k1_reg, s12_x2_reg, s12_p_reg;
    bpt_ctx_t    s12_ctx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s12_vld_reg <= 1'b0;
        else if (en) s12_vld_reg <= s11_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            s12_k1_reg  <= s11_sq_reg * C_P_K1;
            s12_x2_reg  <= asr32(32'd0 - s11_k2_reg, 16);
            s12_p_reg   <= s11_p_reg;
            s12_ctx_reg <= s11_ctx_reg;
        end
    end

    // output register: final pressure, error zeroes the beat
    logic [31:0] pres;
    logic [47:0] out_data_reg;
    logic        out_err_reg;
    assign pres = s12_p_reg + asr32(asr32(s12_k1_reg, 16) + s12_x2_reg + C_P_K3, 4);

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (en) out_vld_reg <= s12_vld_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= s12_ctx_reg.err ? 48'd0 : {pres, s12_ctx_reg.temp};
            out_err_reg  <= s12_ctx_reg.err;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // checks
    logic [12:0] pipe_vld;
    assign pipe_vld = {s1_vld_reg, s2_vld_reg, da_busy, s3_vld_reg, s4_vld_reg, s5_vld_reg,
                       s6_vld_reg, s7_vld_reg, s8_vld_reg, db_busy, s10_vld_reg,
                       s11_vld_reg, s12_vld_reg};

    `BPT_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 48'd0,
        "error beat carries nonzero data")
    `BPT_ASSERT_NEXT(a_stall_freeze, aclk, aresetn, !en, $stable(pipe_vld),
        "pipeline valid bits moved during stall")
    `BPT_ASSERT_NEXT(a_empty_quiet, aclk, aresetn,
        !(|pipe_vld) && !out_vld_reg && !(s_tvalid && s_tready), !m_tvalid,
        "result beat without an item in flight")

endmodule

// ===== src/bpt_udiv.sv =====
// pipelined 32-bit unsigned restoring divider, one quotient bit per stage
// depends on bpt_pkg
module bpt_udiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [31:0]       num,
    input  logic [31:0]       den,
    input  bpt_pkg::bpt_ctx_t in_ctx,
    output logic              out_vld,
    output logic [31:0]       quo,
    output bpt_pkg::bpt_ctx_t out_ctx,
    output logic              busy
);
    import bpt_pkg::*;

    logic              vld_reg [DivStages];
    logic [31:0]       rem_reg [DivStages];
    logic [31:0]       nq_reg  [DivStages];
    logic [31:0]       den_reg [DivStages];
    bpt_ctx_t          ctx_reg [DivStages];
    logic [DivStages-1:0] vld_vec;

    for (genvar i = 0; i < DivStages; i++) begin : g_stage
        logic        v_in;
        logic [31:0] rem_in;
        logic [31:0] nq_in;
        logic [31:0] den_in;
        bpt_ctx_t    c_in;
        logic [32:0] trial;
        logic [32:0] diff;

        if (i == 0) begin : g_first
            assign v_in   = in_vld;
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
            assign c_in   = in_ctx;
        end else begin : g_rest
            assign v_in   = vld_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
            assign c_in   = ctx_reg[i-1];
        end

        // shift in next dividend bit and try subtract
        assign trial = {rem_in, nq_in[31]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= diff[32] ? trial[31:0] : diff[31:0];
                nq_reg[i]  <= {nq_in[30:0], ~diff[32]};
                den_reg[i] <= den_in;
                ctx_reg[i] <= c_in;
            end
        end

        assign vld_vec[i] = vld_reg[i];
    end

    assign out_vld = vld_reg[DivStages-1];
    assign quo     = nq_reg[DivStages-1];
    assign out_ctx = ctx_reg[DivStages-1];
    assign busy    = |vld_vec;

endmodule

// ===== verif/barometer_raw_to_pressure_temperature_unit_checker.sv =====
// checker for the barometer compensation unit: mirrors calibration writes,
// predicts temperature and pressure per input beat and compares result beats
// depends on bpt_pkg for the register index codes
module barometer_raw_to_pressure_temperature_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // temperature_tenths[15:0], pressure_pa[47:16]
    input  logic        m_tuser,   // divide_error
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bpt_pkg::*;

    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] pres;
        logic        err;
    } baro_result_t;

    logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
    logic [1:0]  oss;
    baro_result_t result_queue[$];

    assign pending = result_queue.size();

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    // integer compensation, 32-bit wrapping
    function automatic baro_result_t compensate(input logic [15:0] ut_in,
                                                input logic [18:0] up_in);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b6sq, b7, p, den, num, t;
        baro_result_t r;
        ac1 = sx16(ac1_ac2[31:16]); ac2 = sx16(ac1_ac2[15:0]);
        ac3 = sx16(ac3_ac4[31:16]); ac4 = {16'd0, ac3_ac4[15:0]};
        ac5 = {16'd0, ac5_ac6[31:16]}; ac6 = {16'd0, ac5_ac6[15:0]};
        b1 = sx16(b1_b2[31:16]); b2 = sx16(b1_b2[15:0]);
        mc = sx16(mc_md[31:16]); md = sx16(mc_md[15:0]);
        ut = {16'd0, ut_in};
        up = {13'd0, up_in};
        r = '{temp: 16'd0, pres: 32'd0, err: 1'b1};
        x1 = sra((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        num = mc << 11;
        // most negative over minus one wraps to itself
        if (num == 32'h8000_0000 && den == 32'hFFFF_FFFF) x2 = num;
        else x2 = $signed(num) / $signed(den);
        b5 = x1 + x2;
        t = sra(b5 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        b6sq = sra(b6 * b6, 12);
        x1 = sra(b2 * b6sq, 11);
        x2 = sra(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
        x1 = sra(ac3 * b6, 13);
        x2 = sra(b1 * b6sq, 16);
        x3 = sra(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (32'd50000 >> oss);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * 32'd3038, 16);
        x2 = sra(32'd0 - 32'd7357 * p, 16);
        r.pres = p + sra(x1 + x2 + 32'd3791, 4);
        r.temp = t[15:0];
        r.err = 1'b0;
        return r;
    endfunction

    // mirror writes, predict on input beats, compare on result beats
    always @(posedge aclk) begin
        baro_result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            ac1_ac2 <= '0; ac3_ac4 <= '0; ac5_ac6 <= '0;
            b1_b2 <= '0; mc_md <= '0; oss <= '0;
            result_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_AC1_AC2: ac1_ac2 <= cfg_wdata;
                    REG_AC3_AC4: ac3_ac4 <= cfg_wdata;
                    REG_AC5_AC6: ac5_ac6 <= cfg_wdata;
                    REG_B1_B2:   b1_b2 <= cfg_wdata;
                    REG_MC_MD:   mc_md <= cfg_wdata;
                    REG_OSS:     oss <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                result_queue.push_back(compensate(s_tdata[15:0], s_tdata[34:16]));
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_tdata[15:0] !== want.temp) begin
                        $error("temperature_tenths expected %h got %h", want.temp,
                               m_tdata[15:0]);
                        errs++;
                    end
                    if (m_tdata[47:16] !== want.pres) begin
                        $error("pressure_pa expected %h got %h", want.pres, m_tdata[47:16]);
                        errs++;
                    end
                    if (m_tuser !== want.err) begin
                        $error("divide_error expected %b got %b", want.err, m_tuser);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end
endmodule

// ===== verif/barometer_raw_to_pressure_temperature_unit_tb.sv =====
// stimulus and verdict for the barometer compensation unit
// depends on bpt_pkg, the unit and its checker
module barometer_raw_to_pressure_temperature_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpt_pkg::*;

    localparam int Latency = 76;
    localparam int WatchLimit = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    barometer_raw_to_pressure_temperature_unit uut (.*);
    barometer_raw_to_pressure_temperature_unit_checker chk (.*);

    // result side stall, redrawn per beat
    initial begin
        int gap;
        forever begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog on accepted beats
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn ||
            (stim_done && pending == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input bpt_cfg_idx_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
    endtask

    // one input beat after a random gap
    task automatic send_sample(input logic [15:0] ut, input logic [18:0] up, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, up, ut};
        do @(posedge aclk); while (!s_tready);
    endtask

    // realistic calibration set with random spread
    task automatic load_typical(input logic [1:0] oss);
        write_reg(REG_AC1_AC2, {16'(408 + $urandom_range(0, 800)),
                                16'(-72 - $urandom_range(0, 200))});
        write_reg(REG_AC3_AC4, {16'(-14383 + $urandom_range(0, 2000)),
                                16'(32741 + $urandom_range(0, 1000))});
        write_reg(REG_AC5_AC6, {16'(32757 - $urandom_range(0, 10000)),
                                16'(23153 + $urandom_range(0, 2000))});
        write_reg(REG_B1_B2, {16'(6190 + $urandom_range(0, 200)), 16'(4 + $urandom_range(0, 9))});
        write_reg(REG_MC_MD, {16'(-8711 + $urandom_range(0, 500)),
                              16'(2868 + $urandom_range(0, 200))});
        write_reg(REG_OSS, 32'(oss));
    endtask

    initial begin
        logic [15:0] ut;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero calibration: temperature divisor zero
        send_sample(16'd0, 19'd0, 0);
        send_sample(16'hFFFF, 19'h7FFFF, 0);
        drain();

        // pressure divisor zero: ac4 zero, rest typical
        load_typical(2'd0);
        write_reg(REG_AC3_AC4, 32'hC7D1_0000);
        send_sample(16'd27898, 19'd23843, 0);
        drain();

        // most negative mc over a minus one divisor, wide coefficients
        write_reg(REG_MC_MD, 32'h8000_FFFF);
        write_reg(REG_AC5_AC6, 32'h0000_0000);
        write_reg(REG_AC3_AC4, 32'h8000_FFFF);
        write_reg(REG_AC1_AC2, 32'h7FFF_8000);
        write_reg(REG_B1_B2, 32'h8000_7FFF);
        send_sample(16'd0, 19'd0, 0);
        send_sample(16'hFFFF, 19'h7FFFF, 0);
        drain();

        // extremes of fields across every oversampling setting
        for (int o = 0; o < 4; o++) begin
            load_typical(o[1:0]);
            send_sample(16'd0, 19'd0, 0);
            send_sample(16'hFFFF, 19'h7FFFF, 0);
            send_sample(16'd27898, 19'd23843, 0);
            send_sample(16'h8000, 19'h40000, 1);
            drain();
        end

        // random phases: mostly typical calibration, some fully random
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 4 == 3) begin
                write_reg(REG_AC1_AC2, $urandom());
                write_reg(REG_AC3_AC4, $urandom());
                write_reg(REG_AC5_AC6, $urandom());
                write_reg(REG_B1_B2, $urandom());
                write_reg(REG_MC_MD, $urandom());
                write_reg(REG_OSS, $urandom());
            end else begin
                load_typical(2'($urandom_range(0, 3)));
            end
            for (int i = 0; i < 110; i++) begin
                if ($urandom_range(0, 4) != 0)
                    ut = 16'($urandom_range(20000, 36000));
                else
                    ut = 16'($urandom());
                send_sample(ut, 19'($urandom()), $urandom_range(0, 3) == 0);
            end
            drain();
        end

        stim_done = 1'b1;
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/bpt_pkg.sv
src/bpt_udiv.sv
src/barometer_raw_to_pressure_temperature_unit.sv
verif/barometer_raw_to_pressure_temperature_unit_checker.sv
verif/barometer_raw_to_pressure_temperature_unit_tb.sv
